[rtl/tts_pkg.sv]
// Shared types and constants for the time-slice task scheduler.
// No dependencies; used by timeslice_task_scheduler_top.
package tts_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TICK_WIDTH_DEF = 16;

    // At most this many slots fire on one dispatch
    localparam int MAX_FIRES  = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    // Field widths on the stream ports
    localparam int OPCODE_W   = 4;
    localparam int SLOT_W     = 4;
    localparam int VALUE_W    = 16;
    localparam int CNTDN_W    = 16;
    localparam int RELOAD_W   = 16;
    localparam int TOTAL_W    = 5;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 4'd0,
        OP_DISPATCH = 4'd1,
        OP_SETUP_P  = 4'd2,
        OP_SETUP_O  = 4'd3,
        OP_JOIN     = 4'd4,
        OP_DROP     = 4'd5,
        OP_SET_CD   = 4'd6,
        OP_SET_RL   = 4'd7,
        OP_QUERY    = 4'd8
    } tts_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_WALK,
        ST_FLUSH
    } tts_state_t;

endpackage

[rtl/tts_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/timeslice_task_scheduler_top.sv]
// Time-slice task scheduler, top level.
// Depends on tts_pkg and tts_ram.

// A table of SLOT_COUNT task slots kept in one RAM word per slot (countdown,
// reload, pending, one-shot, joined), with a valid bit per slot in flops so
// that an entry never written reads as zero; there is no clearing pass after
// reset. Commands come in on the s_ stream, one beat each. Single-slot
// commands (setup, join, drop, set countdown, set reload, query) pass a RAM
// read state, then a modify state that writes back with the result beat.
// Tick and dispatch walk every slot through the RAM's single read port, one
// slot per cycle unless the m_ side holds back a fired beat. A tick returns
// one beat for the addressed slot. A dispatch returns one beat per fired
// slot in ascending slot order (tuser = 1, at most 16), tlast on the final
// one; with nothing pending it returns one beat for the addressed slot. The
// result register lets the next command in while a beat is still waiting
// to be taken.
module timeslice_task_scheduler_top #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF,
    parameter int TICK_WIDTH = tts_pkg::TICK_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] opcode, [7:4] slot, [23:8] value
    input  logic [tts_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] slot_index, [4] present, [20:5] countdown_now,
    // [36:21] reload_now, [41:37] joined_total, [47:42] zero
    output logic [tts_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] fires
    output logic                          m_tuser,
    // last result of the command
    output logic                          m_tlast
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IW = $clog2(SLOT_COUNT + 1);   // walk index, holds SLOT_COUNT
    localparam int CW = $clog2(SLOT_COUNT + 1);   // joined count
    localparam int TW = TICK_WIDTH;
    localparam int WW = 2 * TW + 3;               // RAM word
    localparam int P_BIT = 2 * TW;
    localparam int O_BIT = 2 * TW + 1;
    localparam int J_BIT = 2 * TW + 2;

    // ---------------- registers ----------------
    tts_pkg::tts_state_t state_reg, state_next;
    tts_pkg::tts_op_t    op_reg, op_next;
    logic [tts_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [TW-1:0]       value_reg, value_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic                rd_valid_reg, rd_valid_next;

    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [AW-1:0]       proc_idx_reg, proc_idx_next;
    logic                proc_valid_reg, proc_valid_next;
    logic [tts_pkg::FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [tts_pkg::M_TDATA_W-1:0] hold_data_reg, hold_data_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [tts_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    // ---------------- RAM ----------------
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    tts_ram #(
        .WIDTH (WW),
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- shared comb signals ----------------
    logic          in_accept;
    logic          out_free;
    logic          slot_ok;
    logic [AW-1:0] slot_addr;
    logic          walk_issue;
    logic          walk_stall;
    logic          walk_done;
    logic          fire;

    logic [WW-1:0] ent;
    logic [TW-1:0] e_cd, e_rl, cd_dec;
    logic          e_p, e_o, e_j;
    logic [TW-1:0] n_cd, n_rl;
    logic          n_p, n_o, n_j;

    function automatic logic [tts_pkg::M_TDATA_W-1:0] pack_result(
        input logic [tts_pkg::SLOT_W-1:0]   idx,
        input logic                         present,
        input logic [tts_pkg::CNTDN_W-1:0]  cd,
        input logic [tts_pkg::RELOAD_W-1:0] rl,
        input logic [tts_pkg::TOTAL_W-1:0]  total
    );
        pack_result = {6'd0, total, rl, cd, present, idx};
    endfunction

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign slot_ok   = 32'(slot_reg) < SLOT_COUNT;
    assign slot_addr = AW'(slot_reg);

    // Entry being processed; never-written slots read as zero
    assign ent    = rd_valid_reg ? ram_rdata : '0;
    assign e_cd   = ent[TW-1:0];
    assign e_rl   = ent[2*TW-1:TW];
    assign e_p    = ent[P_BIT];
    assign e_o    = ent[O_BIT];
    assign e_j    = ent[J_BIT];
    assign cd_dec = e_cd - TW'(1);

    assign fire = (op_reg == tts_pkg::OP_DISPATCH) && e_j && e_p
                  && (fire_cnt_reg < tts_pkg::FIRE_CNT_W'(tts_pkg::MAX_FIRES));

    // A new fire must push the held beat out first
    assign walk_stall = proc_valid_reg && fire && hold_valid_reg && !out_free;
    assign walk_issue = rd_idx_reg < IW'(SLOT_COUNT);
    assign walk_done  = !proc_valid_reg && !walk_issue;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tts_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (tts_pkg::tts_op_t'(s_tdata[3:0]) == tts_pkg::OP_TICK ||
                        tts_pkg::tts_op_t'(s_tdata[3:0]) == tts_pkg::OP_DISPATCH) begin
                        state_next = tts_pkg::ST_WALK;
                    end else begin
                        state_next = tts_pkg::ST_RD;
                    end
                end
            end
            tts_pkg::ST_RD: begin
                state_next = tts_pkg::ST_MOD;
            end
            tts_pkg::ST_MOD: begin
                if (out_free) begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_WALK: begin
                if (!walk_stall && walk_done) begin
                    // no fires: fall back to a report on the addressed slot
                    state_next = hold_valid_reg ? tts_pkg::ST_FLUSH : tts_pkg::ST_RD;
                end
            end
            tts_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        op_next         = op_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        proc_idx_next   = proc_idx_reg;
        proc_valid_next = proc_valid_reg;
        fire_cnt_next   = fire_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = slot_addr;
        ram_re    = 1'b0;
        ram_raddr = slot_addr;

        n_cd = e_cd;
        n_rl = e_rl;
        n_p  = e_p;
        n_o  = e_o;
        n_j  = e_j;

        case (state_reg)
            tts_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                // tready is high throughout idle, so tvalid alone accepts
                if (s_tvalid) begin
                    op_next         = tts_pkg::tts_op_t'(s_tdata[3:0]);
                    slot_next       = s_tdata[7:4];
                    value_next      = TW'(s_tdata[23:8]);
                    rd_idx_next     = '0;
                    proc_valid_next = 1'b0;
                    fire_cnt_next   = '0;
                    hold_valid_next = 1'b0;
                end
            end

            tts_pkg::ST_RD: begin
                ram_re    = 1'b1;
                ram_raddr = slot_addr;
            end

            tts_pkg::ST_MOD: begin
                if (slot_ok) begin
                    case (op_reg)
                        tts_pkg::OP_SETUP_P, tts_pkg::OP_SETUP_O: begin
                            if (e_j) begin
                                n_j        = 1'b0;
                                count_next = count_reg - CW'(1);
                            end
                            n_cd = value_reg;
                            n_rl = value_reg;
                            n_p  = 1'b0;
                            n_o  = (op_reg == tts_pkg::OP_SETUP_O);
                        end
                        tts_pkg::OP_JOIN: begin
                            if (!e_j) begin
                                n_j        = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        tts_pkg::OP_DROP: begin
                            if (e_j) begin
                                n_j        = 1'b0;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        tts_pkg::OP_SET_CD: n_cd = value_reg;
                        tts_pkg::OP_SET_RL: n_rl = value_reg;
                        default: ;
                    endcase
                end
                if (out_free) begin
                    ram_we    = slot_ok;
                    ram_waddr = slot_addr;
                    if (slot_ok) begin
                        valid_next[slot_addr] = 1'b1;
                    end else begin
                        count_next = count_reg;
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = pack_result(slot_reg, slot_ok && n_j,
                                                slot_ok ? 16'(n_cd) : '0,
                                                slot_ok ? 16'(n_rl) : '0,
                                                5'(count_next));
                end else begin
                    count_next = count_reg;
                end
            end

            tts_pkg::ST_WALK: begin
                if (op_reg == tts_pkg::OP_TICK) begin
                    if (e_j && e_cd != '0) begin
                        if (cd_dec == '0) begin
                            n_cd = e_rl;
                            n_p  = 1'b1;
                        end else begin
                            n_cd = cd_dec;
                        end
                    end
                end else if (fire) begin
                    n_p = 1'b0;
                    if (e_o) begin
                        n_j = 1'b0;
                    end
                end
                if (!walk_stall) begin
                    if (proc_valid_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = proc_idx_reg;
                        valid_next[proc_idx_reg] = 1'b1;
                        if (fire) begin
                            if (e_o) begin
                                count_next = count_reg - CW'(1);
                            end
                            fire_cnt_next = fire_cnt_reg + tts_pkg::FIRE_CNT_W'(1);
                            if (hold_valid_reg) begin
                                m_tvalid_next = 1'b1;
                                m_tuser_next  = 1'b1;
                                m_tlast_next  = 1'b0;
                                m_tdata_next  = hold_data_reg;
                            end
                            hold_valid_next = 1'b1;
                            hold_data_next  = pack_result(4'(proc_idx_reg), n_j,
                                                          16'(n_cd), 16'(n_rl),
                                                          5'(count_next));
                        end
                    end
                    ram_re          = walk_issue;
                    ram_raddr       = AW'(rd_idx_reg);
                    proc_valid_next = walk_issue;
                    proc_idx_next   = AW'(rd_idx_reg);
                    if (walk_issue) begin
                        rd_idx_next = rd_idx_reg + IW'(1);
                    end
                end
            end

            tts_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tuser_next    = 1'b1;
                    m_tlast_next    = 1'b1;
                    m_tdata_next    = hold_data_reg;
                    hold_valid_next = 1'b0;
                end
            end

            default: ;
        endcase

        // valid flag travels with the registered RAM read
        if (ram_re) begin
            rd_valid_next = (32'(ram_raddr) < SLOT_COUNT) ? valid_reg[ram_raddr] : 1'b0;
        end

        ram_wdata = {n_j, n_o, n_p, n_rl, n_cd};
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tts_pkg::ST_IDLE;
            count_reg      <= '0;
            valid_reg      <= '0;
            proc_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            proc_valid_reg <= proc_valid_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        value_reg     <= value_next;
        rd_valid_reg  <= rd_valid_next;
        rd_idx_reg    <= rd_idx_next;
        proc_idx_reg  <= proc_idx_next;
        fire_cnt_reg  <= fire_cnt_next;
        hold_data_reg <= hold_data_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[verif/tb_timeslice_task_scheduler_top.sv]
// Self-checking testbench for timeslice_task_scheduler_top: slot-table predictor,
// directed and random command streams, random stalls on both stream sides.
// Depends on tts_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_timeslice_task_scheduler_top;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 12;
    // worst item: a full slot walk + a 16-beat burst under stalls + sender gap;
    // ~160 items in all, taken many times over
    localparam int CYCLE_LIMIT = 200000;
    // settle time after the last expected beat, above one full slot walk
    localparam int TAIL_CYCLES = 64;
    localparam int RAND_ITEMS  = 104;
    localparam int QUIET_ITEMS = 40;
    localparam int REPORT_MAX  = 10;

    // opcodes the block treats as a plain query
    localparam logic [tts_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = 4'd9;
    localparam logic [tts_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = 4'd15;

    // One result beat as the block reports it
    typedef struct packed {
        logic [tts_pkg::SLOT_W-1:0]   slot_index;
        logic                         fires;
        logic                         last;
        logic                         present;
        logic [tts_pkg::CNTDN_W-1:0]  countdown_now;
        logic [tts_pkg::RELOAD_W-1:0] reload_now;
        logic [tts_pkg::TOTAL_W-1:0]  joined_total;
    } slot_beat_t;

    // Slot table shadow plus the queue of beats it predicts
    class slot_table_scoreboard;
        logic [tts_pkg::VALUE_W-1:0] countdown [tts_pkg::SLOT_COUNT_DEF];
        logic [tts_pkg::VALUE_W-1:0] reload    [tts_pkg::SLOT_COUNT_DEF];
        bit                          pending   [tts_pkg::SLOT_COUNT_DEF];
        bit                          oneshot   [tts_pkg::SLOT_COUNT_DEF];
        bit                          joined    [tts_pkg::SLOT_COUNT_DEF];
        logic [tts_pkg::TOTAL_W-1:0] joined_cnt;
        slot_beat_t                  beats_due [$];
        int unsigned                 err_cnt;

        function new();
            foreach (countdown[i]) begin
                countdown[i] = '0;
                reload[i]    = '0;
                pending[i]   = 1'b0;
                oneshot[i]   = 1'b0;
                joined[i]    = 1'b0;
            end
            joined_cnt = '0;
            err_cnt    = 0;
        endfunction

        function void leave_table(int s);
            if (joined[s]) begin
                joined[s]  = 1'b0;
                joined_cnt = joined_cnt - 1'b1;
            end
        endfunction

        // snapshot of one slot right after its own update
        function slot_beat_t slot_view(int s, bit fires, bit last);
            slot_beat_t b;
            b.slot_index    = tts_pkg::SLOT_W'(s);
            b.fires         = fires;
            b.last          = last;
            b.present       = joined[s];
            b.countdown_now = countdown[s];
            b.reload_now    = reload[s];
            b.joined_total  = joined_cnt;
            return b;
        endfunction

        // Called once per accepted command beat
        function void note_command(logic [tts_pkg::OPCODE_W-1:0] op,
                                   logic [tts_pkg::SLOT_W-1:0] s,
                                   logic [tts_pkg::VALUE_W-1:0] v);
            slot_beat_t fired_q [$];
            slot_beat_t b;
            if (op == tts_pkg::OP_DISPATCH) begin
                for (int i = 0; i < tts_pkg::SLOT_COUNT_DEF &&
                                fired_q.size() < tts_pkg::MAX_FIRES; i++) begin
                    if (joined[i] && pending[i]) begin
                        pending[i] = 1'b0;
                        if (oneshot[i])
                            leave_table(i);
                        fired_q.push_back(slot_view(i, 1'b1, 1'b0));
                    end
                end
                if (fired_q.size() == 0) begin
                    beats_due.push_back(slot_view(s, 1'b0, 1'b1));
                end else begin
                    b = fired_q.pop_back();
                    b.last = 1'b1;
                    fired_q.push_back(b);
                    foreach (fired_q[k])
                        beats_due.push_back(fired_q[k]);
                end
                return;
            end
            case (op)
                tts_pkg::OP_TICK: begin
                    for (int i = 0; i < tts_pkg::SLOT_COUNT_DEF; i++) begin
                        if (joined[i] && countdown[i] != '0) begin
                            countdown[i] = countdown[i] - 1'b1;
                            if (countdown[i] == '0) begin
                                countdown[i] = reload[i];
                                pending[i]   = 1'b1;
                            end
                        end
                    end
                end
                tts_pkg::OP_SETUP_P, tts_pkg::OP_SETUP_O: begin
                    leave_table(s);
                    reload[s]    = v;
                    countdown[s] = v;
                    pending[s]   = 1'b0;
                    oneshot[s]   = (op == tts_pkg::OP_SETUP_O);
                end
                tts_pkg::OP_JOIN: begin
                    if (!joined[s]) begin
                        joined[s]  = 1'b1;
                        joined_cnt = joined_cnt + 1'b1;
                    end
                end
                tts_pkg::OP_DROP:   leave_table(s);
                tts_pkg::OP_SET_CD: countdown[s] = v;
                tts_pkg::OP_SET_RL: reload[s] = v;
                default: ;  // query and spare codes leave the table alone
            endcase
            beats_due.push_back(slot_view(s, 1'b0, 1'b1));
        endfunction

        function void flag_error(string msg);
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void match_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
                flag_error($sformatf("%s expected %0h got %0h", name, want, got));
        endfunction

        // Called once per accepted result beat
        function void check_beat(logic [tts_pkg::M_TDATA_W-1:0] data, logic user, logic lst);
            slot_beat_t want;
            if (beats_due.size() == 0) begin
                flag_error($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                     data, user, lst));
                return;
            end
            want = beats_due.pop_front();
            match_field("slot_index",    want.slot_index,    data[3:0]);
            match_field("present",       want.present,       data[4]);
            match_field("countdown_now", want.countdown_now, data[20:5]);
            match_field("reload_now",    want.reload_now,    data[36:21]);
            match_field("joined_total",  want.joined_total,  data[41:37]);
            match_field("tdata pad",     0,                  data[47:42]);
            match_field("fires",         want.fires,         user);
            match_field("last",          want.last,          lst);
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [tts_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [tts_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    slot_table_scoreboard sb = new();

    bit          idle_on;     // random gaps/stalls allowed right now
    int unsigned sent_cnt;
    int unsigned cycle_cnt;

    timeslice_task_scheduler_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Every input known from time zero
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        idle_on  = 1'b1;
        sent_cnt = 0;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end
    initial cycle_cnt = 0;

    // Result side: random stall bursts, changed at falling edge
    initial begin : ready_gen
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor: outputs sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser, m_tlast);
    end

    // Drive one command beat; entered and left just after a falling edge.
    // tvalid is only lowered for a gap, so it never sees two updates in a step.
    task automatic send_cmd(input logic [tts_pkg::OPCODE_W-1:0] op,
                            input logic [tts_pkg::SLOT_W-1:0] s,
                            input logic [tts_pkg::VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, s, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, s, v);
        @(negedge aclk);
        sent_cnt++;
    endtask

    // Hold the command side off until every predicted beat has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.beats_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly short periods so slots fire often; now and then any 16-bit value
    function automatic logic [tts_pkg::VALUE_W-1:0] pick_ticks();
        if ($urandom_range(0, 3) == 0)
            return tts_pkg::VALUE_W'($urandom);
        return tts_pkg::VALUE_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [tts_pkg::OPCODE_W-1:0] pick_setup();
        return $urandom_range(0, 1) ? tts_pkg::OP_SETUP_O : tts_pkg::OP_SETUP_P;
    endfunction

    initial begin : stimulus
        int unsigned rand_stop;
        int unsigned quiet_from;
        int unsigned pause_at;
        bit          paused;
        logic [tts_pkg::SLOT_W-1:0] s;

        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        send_cmd(tts_pkg::OP_QUERY,    4'd0,  16'h0000);  // fresh table
        send_cmd(tts_pkg::OP_SETUP_P,  4'd0,  16'h0001);
        send_cmd(tts_pkg::OP_JOIN,     4'd0,  16'hFFFF);
        send_cmd(tts_pkg::OP_TICK,     4'd0,  16'h0000);  // slot 0 hits zero, reloads
        send_cmd(tts_pkg::OP_DISPATCH, 4'd0,  16'h0000);  // slot 0 fires
        send_cmd(tts_pkg::OP_DISPATCH, 4'd15, 16'h0000);  // nothing pending
        send_cmd(tts_pkg::OP_SETUP_O,  4'd15, 16'hFFFF);
        send_cmd(tts_pkg::OP_SET_CD,   4'd15, 16'h0001);
        send_cmd(tts_pkg::OP_JOIN,     4'd15, 16'h0000);
        send_cmd(tts_pkg::OP_JOIN,     4'd15, 16'h0000);  // already joined
        send_cmd(tts_pkg::OP_TICK,     4'd7,  16'hFFFF);  // slots 0 and 15 pending
        send_cmd(tts_pkg::OP_DROP,     4'd0,  16'h0000);  // keeps its pending mark
        send_cmd(tts_pkg::OP_DROP,     4'd0,  16'h0000);  // drop of an unjoined slot
        send_cmd(tts_pkg::OP_DISPATCH, 4'd3,  16'h0000);  // one-shot 15 fires and leaves
        send_cmd(tts_pkg::OP_JOIN,     4'd0,  16'h0000);
        send_cmd(tts_pkg::OP_DISPATCH, 4'd0,  16'h0000);  // pending kept across the drop
        send_cmd(tts_pkg::OP_SETUP_P,  4'd0,  16'h0002);  // setup of a joined slot
        send_cmd(tts_pkg::OP_SETUP_P,  4'd3,  16'h0000);  // zero countdown
        send_cmd(tts_pkg::OP_JOIN,     4'd3,  16'h0000);
        send_cmd(tts_pkg::OP_TICK,     4'd3,  16'h0000);  // slot 3 must not go pending
        send_cmd(tts_pkg::OP_SET_RL,   4'd3,  16'hFFFF);
        send_cmd(OP_SPARE_FIRST, 4'd3, 16'h5A5A);
        send_cmd(OP_SPARE_LAST,  4'd3, 16'hA5A5);

        // ---- every slot fires on one dispatch: the full 16-beat burst ----
        for (int i = 0; i < tts_pkg::SLOT_COUNT_DEF; i++) begin
            send_cmd(pick_setup(), tts_pkg::SLOT_W'(i), 16'h0001);
            send_cmd(tts_pkg::OP_JOIN, tts_pkg::SLOT_W'(i), tts_pkg::VALUE_W'($urandom));
        end
        send_cmd(tts_pkg::OP_TICK, tts_pkg::SLOT_W'($urandom),
                 tts_pkg::VALUE_W'($urandom));
        send_cmd(tts_pkg::OP_DISPATCH, tts_pkg::SLOT_W'($urandom),
                 tts_pkg::VALUE_W'($urandom));

        // ---- random part: mostly arm / tick-run / dispatch, some noise ----
        rand_stop  = sent_cnt + RAND_ITEMS;
        quiet_from = rand_stop - QUIET_ITEMS;
        pause_at   = sent_cnt + RAND_ITEMS / 2;
        paused     = 1'b0;
        while (sent_cnt < rand_stop) begin
            if (sent_cnt >= quiet_from)
                idle_on = 1'b0;
            else if ($urandom_range(0, 3) == 0)
                idle_on = ($urandom_range(0, 3) != 0);  // some stretches run flat out
            if (!paused && sent_cnt >= pause_at) begin
                wait_drain();
                paused = 1'b1;
            end
            s = tts_pkg::SLOT_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_cmd(pick_setup(), s, pick_ticks());
                    send_cmd(tts_pkg::OP_JOIN, s, tts_pkg::VALUE_W'($urandom));
                end
                3, 4, 5, 6: begin
                    repeat ($urandom_range(1, 4))
                        send_cmd(tts_pkg::OP_TICK, tts_pkg::SLOT_W'($urandom),
                                 tts_pkg::VALUE_W'($urandom));
                    send_cmd(tts_pkg::OP_DISPATCH, tts_pkg::SLOT_W'($urandom),
                             tts_pkg::VALUE_W'($urandom));
                end
                7: begin
                    case ($urandom_range(0, 2))
                        0:       send_cmd(tts_pkg::OP_DROP, s, tts_pkg::VALUE_W'($urandom));
                        1:       send_cmd(tts_pkg::OP_SET_CD, s, pick_ticks());
                        default: send_cmd(tts_pkg::OP_SET_RL, s, pick_ticks());
                    endcase
                end
                default: begin
                    send_cmd(tts_pkg::OPCODE_W'($urandom_range(0, OP_SPARE_LAST)), s,
                             tts_pkg::VALUE_W'($urandom));
                end
            endcase
        end

        // ---- wind down ----
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.err_cnt == 0 && sb.beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/timeslice_task_scheduler_top.sv
verif/tb_timeslice_task_scheduler_top.sv
